@@ rtl/core/clnw_pkg.sv @@
// ----------------------------------------------------------------------------
// clnw_pkg
// shared types and constants of the character lcd nibble writer
// ----------------------------------------------------------------------------
package clnw_pkg;

   localparam int INIT_LEN = 12;
   localparam int IDX_W    = 4;

   // nibble sequence positions that close a run
   localparam logic [IDX_W-1:0] INIT_LAST_IDX = IDX_W'(INIT_LEN - 1);
   localparam logic [IDX_W-1:0] CHAR_LAST_IDX = IDX_W'(1);

   // input kind carried on the request tuser bit
   localparam logic FUNC_INIT = 1'b0;
   localparam logic FUNC_CHAR = 1'b1;

   // register select levels
   localparam logic RS_COMMAND = 1'b0;
   localparam logic RS_DATA    = 1'b1;

   // classified work item handed from the front to the back
   typedef struct packed {
      logic       is_char;
      logic [7:0] code;
   } clnw_desc_type;

   // queue status seen by the front and the back
   typedef struct packed {
      logic valid;
      logic full;
   } clnw_qstat_type;

   // power-up command nibbles for 4-bit mode
   function automatic logic [3:0] init_nibble(input logic [IDX_W-1:0] idx);
      logic [3:0] nib;
      begin
         unique case (idx)
            4'd0, 4'd1, 4'd2: nib = 4'h3;  // wake-up
            4'd3:             nib = 4'h2;  // switch to 4-bit bus
            4'd4:             nib = 4'h2;  // function set, high
            4'd5:             nib = 4'h8;  // two lines, 5x8 font
            4'd6:             nib = 4'h0;  // display control, high
            4'd7:             nib = 4'hF;  // display, cursor, blink on
            4'd8:             nib = 4'h0;  // entry mode, high
            4'd9:             nib = 4'h6;  // increment
            4'd10:            nib = 4'h0;  // clear, high
            4'd11:            nib = 4'h1;  // clear display
            default:          nib = 4'h0;
         endcase
         return nib;
      end
   endfunction

endpackage

@@ rtl/core/clnw_front.sv @@
// ----------------------------------------------------------------------------
// clnw_front
// request intake: while the queue has room, registers and classifies one item per cycle
// ----------------------------------------------------------------------------
module clnw_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,
   input  logic                    req_tuser,
   input  clnw_pkg::clnw_qstat_type q_stat,
   output logic                    push,
   output clnw_pkg::clnw_desc_type push_desc
);
   import clnw_pkg::*;

   logic          valid_ff, valid_in;
   clnw_desc_type desc_ff, desc_in;
   logic          accept;

   assign push       = valid_ff && !q_stat.full;
   assign req_tready = !valid_ff || !q_stat.full;
   assign accept     = req_tvalid && req_tready;
   assign push_desc  = desc_ff;

   always_comb begin
      valid_in = valid_ff;
      desc_in  = desc_ff;
      if (accept) begin
         valid_in        = 1'b1;
         desc_in.is_char = (req_tuser == FUNC_CHAR);
         desc_in.code    = req_tdata;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      desc_ff <= desc_in;
   end

endmodule

@@ rtl/core/clnw_queue.sv @@
// ----------------------------------------------------------------------------
// clnw_queue
// two-entry queue between intake and sequencer
// ----------------------------------------------------------------------------
module clnw_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  clnw_pkg::clnw_desc_type  push_desc,
   input  logic                     pop,
   output clnw_pkg::clnw_desc_type  pop_desc,
   output clnw_pkg::clnw_qstat_type q_stat
);
   import clnw_pkg::*;

   clnw_desc_type mem_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          do_push, do_pop;

   assign q_stat.valid = (count_ff != 2'd0);
   assign q_stat.full  = (count_ff == 2'd2);
   assign do_push      = push && !q_stat.full;
   assign do_pop       = pop && q_stat.valid;
   assign pop_desc     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

@@ rtl/core/clnw_back.sv @@
// ----------------------------------------------------------------------------
// clnw_back
// nibble sequencer: one enable pulse per nibble, results into output register
// ----------------------------------------------------------------------------
module clnw_back #(
   parameter int PULSE_CYCLES = 3200
) (
   input  logic                     clock,
   input  logic                     reset,
   input  clnw_pkg::clnw_qstat_type q_stat,
   input  clnw_pkg::clnw_desc_type  pop_desc,
   output logic                     pop,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [7:0]               rsp_tdata,
   output logic                     rsp_tuser,
   output logic                     rsp_tlast
);
   import clnw_pkg::*;

   localparam int TW = (PULSE_CYCLES > 1) ? $clog2(PULSE_CYCLES) : 1;
   localparam logic [TW-1:0] TIMER_MAX = TW'(PULSE_CYCLES - 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type       state_ff, state_in;
   logic            is_char_ff, is_char_in;
   logic [7:0]      code_ff, code_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [TW-1:0]   timer_ff, timer_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [3:0]      nib_ff, nib_in;
   logic            rs_ff, rs_in;
   logic            last_ff, last_in;

   logic            done, out_free, fire, cur_last, load;
   logic [3:0]      cur_nib;

   assign done     = (state_ff == ST_RUN) && (timer_ff == TIMER_MAX);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign fire     = done && out_free;
   assign cur_last = is_char_ff ? (idx_ff == CHAR_LAST_IDX) : (idx_ff == INIT_LAST_IDX);
   assign load     = q_stat.valid && ((state_ff == ST_IDLE) || (fire && cur_last));
   assign pop      = load;

   // high nibble first for characters
   always_comb begin
      if (is_char_ff) begin
         cur_nib = (idx_ff == '0) ? code_ff[7:4] : code_ff[3:0];
      end else begin
         cur_nib = init_nibble(idx_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      is_char_in   = is_char_ff;
      code_in      = code_ff;
      idx_in       = idx_ff;
      timer_in     = timer_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      nib_in       = nib_ff;
      rs_in        = rs_ff;
      last_in      = last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (load) begin
               state_in   = ST_RUN;
               is_char_in = pop_desc.is_char;
               code_in    = pop_desc.code;
               idx_in     = '0;
               timer_in   = '0;
            end
         end
         ST_RUN: begin
            if (fire) begin
               rsp_valid_in = 1'b1;
               nib_in       = cur_nib;
               rs_in        = is_char_ff ? RS_DATA : RS_COMMAND;
               last_in      = cur_last;
               timer_in     = '0;
               idx_in       = idx_ff + IDX_W'(1);
               if (cur_last) begin
                  if (load) begin
                     is_char_in = pop_desc.is_char;
                     code_in    = pop_desc.code;
                     idx_in     = '0;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end else if (!done) begin
               timer_in = timer_ff + TW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         timer_ff     <= '0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         timer_ff     <= timer_in;
         idx_ff       <= idx_in;
      end
      is_char_ff <= is_char_in;
      code_ff    <= code_in;
      nib_ff     <= nib_in;
      rs_ff      <= rs_in;
      last_ff    <= last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, nib_ff};
   assign rsp_tuser  = rs_ff;
   assign rsp_tlast  = last_ff;

endmodule

@@ rtl/core/char_lcd_nibble_writer.sv @@
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer
// 4-bit character display writer: init runs and characters to nibble pulses
// ----------------------------------------------------------------------------
//
// channel   dir  tdata              tuser          tlast
// req_      in   [7:0] char_code    [0] func       -
// rsp_      out  [3:0] bus_nibble   [0] reg_select last nibble of a run
//
// each nibble holds the enable pulse until the pulse timer in the sequencer,
// set by PULSE_CYCLES, runs out; a character is two nibbles and an init run
// twelve, with no gap between runs while items wait. the intake takes one
// item per cycle while the queue has room, into a two-entry queue, so requests
// keep flowing while the sequencer is busy; a stalled output holds the timer.
// synchronous active-high reset empties the intake, queue and output register.
//
module char_lcd_nibble_writer #(
   parameter int PULSE_CYCLES = 3200
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_code
   input  logic       req_tuser,   // [0] func: 0 init run, 1 character
   // result channel, one transfer per enable pulse
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [3:0] bus_nibble, [7:4] zero
   output logic       rsp_tuser,   // [0] reg_select: 0 command, 1 data
   output logic       rsp_tlast
);
   import clnw_pkg::*;

   clnw_qstat_type q_stat;
   clnw_desc_type  push_desc;
   clnw_desc_type  pop_desc;
   logic           push;
   logic           pop;

   // intake and classify
   clnw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_stat     (q_stat),
      .push       (push),
      .push_desc  (push_desc)
   );

   // decoupling queue
   clnw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .pop_desc  (pop_desc),
      .q_stat    (q_stat)
   );

   // nibble sequencer and output register
   clnw_back #(
      .PULSE_CYCLES (PULSE_CYCLES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_stat     (q_stat),
      .pop_desc   (pop_desc),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef NO_ASSERTIONS
   // nothing comes out in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a command run always ends on the clear-display nibble
   a_init_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast && (rsp_tuser == RS_COMMAND) |-> (rsp_tdata[3:0] == 4'h1))
      else $error("command run ended on a wrong nibble");

   // the queue is never popped while empty
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_stat.valid)
      else $error("pop from empty queue");

   // the intake only pushes into a queue with room
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_stat.full)
      else $error("push into full queue");
`endif

endmodule
